### rtl/core/otpg_pkg.sv
package otpg_pkg;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 2;
    localparam int CLK_W     = 25;
    localparam int TONE_W    = 13;
    localparam int FREQ_W    = 16;
    localparam int PER_W     = 16;
    localparam int OCT_W     = 3;
    localparam int REG_IDX_W = 3;
    localparam int DVD_W     = CLK_W + 1;
    localparam int CNT_W     = $clog2(DVD_W);
    localparam int NUM_TONES = 4;

    localparam logic [CMD_W-1:0] CMD_TONE_ON  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TONE_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OCT_UP   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_OCT_DOWN = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_CLOCK = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TONE0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TONE1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TONE2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TONE3 = 3'd4;

    localparam logic [CLK_W-1:0]  CLOCK_RST = 25'd3333333;
    localparam logic [TONE_W-1:0] TONE0_RST = 13'd358;
    localparam logic [TONE_W-1:0] TONE1_RST = 13'd301;
    localparam logic [TONE_W-1:0] TONE2_RST = 13'd478;
    localparam logic [TONE_W-1:0] TONE3_RST = 13'd179;

    localparam logic signed [OCT_W-1:0] OCT_MAX = 3'sd3;
    localparam logic signed [OCT_W-1:0] OCT_MIN = -3'sd3;

    localparam logic [PER_W-1:0] PERIOD_SAT = 16'hFFFF;
    localparam logic [PER_W-1:0] PERIOD_RST = 16'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } otpg_div_stat_t;

endpackage

### rtl/core/otpg_if.sv
interface otpg_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [otpg_pkg::CMD_W-1:0]   command;
    logic [otpg_pkg::IDX_W-1:0]   tone_sel;

    modport source (output valid, command, tone_sel, input ready);
    modport sink (input valid, command, tone_sel, output ready);
endinterface

interface otpg_res_if;
    logic                               valid;
    logic                               ready;
    logic [otpg_pkg::PER_W-1:0]         period;
    logic [otpg_pkg::PER_W-1:0]         compare;
    logic signed [otpg_pkg::OCT_W-1:0]  octave_now;

    modport source (output valid, period, compare, octave_now, input ready);
    modport sink (input valid, period, compare, octave_now, output ready);
endinterface

interface otpg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [otpg_pkg::REG_IDX_W-1:0]   index;
    logic [otpg_pkg::CLK_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/otpg_div.sv
module otpg_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [otpg_pkg::DVD_W-1:0]        dividend,
    input  logic [otpg_pkg::FREQ_W-1:0]       divisor,
    output otpg_pkg::otpg_div_stat_t          stat,
    output logic [otpg_pkg::DVD_W-1:0]        quotient
);

    localparam int DW = otpg_pkg::DVD_W;
    localparam int FW = otpg_pkg::FREQ_W;
    localparam int CW = otpg_pkg::CNT_W;

    logic [DW-1:0] dvd_reg, dvd_next;
    logic [FW-1:0] rem_reg, rem_next;
    logic [FW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [FW:0]   shifted;
    logic [FW+1:0] diff;
    logic          ge;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[DW-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        ge        = ~diff[FW+1];
        rem_next  = ge ? diff[FW-1:0] : shifted[FW-1:0];
        dvd_next  = {dvd_reg[DW-2:0], ge};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule

### rtl/core/octave_tone_period_generator.sv
// Each command word yields one result word with the period, compare value and octave that
// hold after it. For tone on, the divider is loaded at acceptance with the shifted base
// frequency and the rounded dividend, shifts one quotient bit per cycle until all dividend
// bits are shifted, then the sequencer latches the period and compare value and loads the
// output register. Tone off, octave up or down, and a tone on whose shifted frequency is
// zero go straight to loading the output register. The next command word is taken once a
// result has been loaded. A new command word is taken while the last result word still
// waits at the output; the block then holds its next result until the output register is
// free.
// Configuration writes complete at once and are meant for times when the block is idle.
module octave_tone_period_generator (
    input  logic          clk,
    input  logic          rst_n,
    otpg_cmd_if.sink      cmd,
    otpg_res_if.source    res,
    otpg_cfg_if.sink      cfg
);

    localparam int DW = otpg_pkg::DVD_W;
    localparam int FW = otpg_pkg::FREQ_W;
    localparam int PW = otpg_pkg::PER_W;
    localparam int OW = otpg_pkg::OCT_W;
    localparam int TW = otpg_pkg::TONE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [otpg_pkg::CLK_W-1:0]  clock_reg;
    logic [TW-1:0]               tone_reg [otpg_pkg::NUM_TONES];
    logic signed [OW-1:0]        octave_reg, octave_next;
    logic [PW-1:0]               period_reg, period_next;
    logic [PW-1:0]               compare_reg, compare_next;
    logic                        res_valid_reg, res_valid_next;
    logic [PW-1:0]               per_out_reg;
    logic [PW-1:0]               cmp_out_reg;
    logic signed [OW-1:0]        oct_out_reg;

    logic                        cmd_fire;
    logic                        res_load;
    logic [FW-1:0]               freq_ext;
    logic [FW-1:0]               freq_sh;
    logic [OW-1:0]               oct_neg;
    logic [DW-1:0]               dividend;
    logic                        div_start;
    otpg_pkg::otpg_div_stat_t    div_stat;
    logic [DW-1:0]               quotient;
    logic [DW-1:0]               q_adj;
    logic [DW-1:0]               q_m1;
    logic [PW-1:0]               per_calc;
    logic [PW:0]                 cmp_sum;
    logic [PW-1:0]               cmp_calc;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign cmd_fire  = cmd.valid && cmd.ready;

    always_comb
    begin
        freq_ext = {{(FW - TW){1'b0}}, tone_reg[cmd.tone_sel]};
        oct_neg  = -octave_reg;
        if (octave_reg > 0)
        begin
            freq_sh = freq_ext << octave_reg[1:0];
        end
        else if (octave_reg < 0)
        begin
            freq_sh = freq_ext >> oct_neg[1:0];
        end
        else
        begin
            freq_sh = freq_ext;
        end
        dividend  = {1'b0, clock_reg} + {{(DW - FW + 1){1'b0}}, freq_sh[FW-1:1]};
        div_start = cmd_fire && (cmd.command == otpg_pkg::CMD_TONE_ON) && (freq_sh != '0);
    end

    otpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (freq_sh),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_comb
    begin
        q_adj    = (quotient == '0) ? DW'(1) : quotient;
        q_m1     = q_adj - 1'b1;
        per_calc = (|q_m1[DW-1:PW]) ? otpg_pkg::PERIOD_SAT : q_m1[PW-1:0];
        cmp_sum  = {1'b0, per_calc} + 1'b1;
        cmp_calc = cmp_sum[PW:1];
    end

    always_comb
    begin
        state_next     = state_reg;
        octave_next    = octave_reg;
        period_next    = period_reg;
        compare_next   = compare_reg;
        res_load       = 1'b0;
        res_valid_next = res_valid_reg && !res.ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = ST_DONE;
                    unique case (cmd.command)
                        otpg_pkg::CMD_TONE_ON:
                        begin
                            if (freq_sh == '0)
                            begin
                                compare_next = '0;
                            end
                            else
                            begin
                                state_next = ST_DIV;
                            end
                        end
                        otpg_pkg::CMD_TONE_OFF:
                        begin
                            compare_next = '0;
                        end
                        otpg_pkg::CMD_OCT_UP:
                        begin
                            if (octave_reg != otpg_pkg::OCT_MAX)
                            begin
                                octave_next = octave_reg + 1'b1;
                            end
                        end
                        otpg_pkg::CMD_OCT_DOWN:
                        begin
                            if (octave_reg != otpg_pkg::OCT_MIN)
                            begin
                                octave_next = octave_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    period_next  = per_calc;
                    compare_next = cmp_calc;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_load       = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            octave_reg    <= '0;
            period_reg    <= otpg_pkg::PERIOD_RST;
            compare_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            octave_reg    <= octave_next;
            period_reg    <= period_next;
            compare_reg   <= compare_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg   <= otpg_pkg::CLOCK_RST;
            tone_reg[0] <= otpg_pkg::TONE0_RST;
            tone_reg[1] <= otpg_pkg::TONE1_RST;
            tone_reg[2] <= otpg_pkg::TONE2_RST;
            tone_reg[3] <= otpg_pkg::TONE3_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                otpg_pkg::REG_CLOCK: clock_reg   <= cfg.data;
                otpg_pkg::REG_TONE0: tone_reg[0] <= cfg.data[TW-1:0];
                otpg_pkg::REG_TONE1: tone_reg[1] <= cfg.data[TW-1:0];
                otpg_pkg::REG_TONE2: tone_reg[2] <= cfg.data[TW-1:0];
                otpg_pkg::REG_TONE3: tone_reg[3] <= cfg.data[TW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            per_out_reg <= period_reg;
            cmp_out_reg <= compare_reg;
            oct_out_reg <= octave_reg;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.period     = per_out_reg;
    assign res.compare    = cmp_out_reg;
    assign res.octave_now = oct_out_reg;

`ifndef SYNTHESIS
    // The octave stays inside its saturating range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (octave_reg <= otpg_pkg::OCT_MAX) && (octave_reg >= otpg_pkg::OCT_MIN))
        else $error("octave left its range");

    // The divider never runs while a new command word can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_stat.busy)
        else $error("divider busy while idle");

    // A divider result only arrives while a tone-on command is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside of a division");

    // A nonzero compare value is always (period + 1) / 2, rounded down.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (cmp_out_reg != '0)) |->
        (cmp_out_reg == PW'(({1'b0, per_out_reg} + 1'b1) >> 1)))
        else $error("compare value does not match period");

    // Starting a division moves the sequencer into the division state.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIV))
        else $error("division started without entering its state");
`endif

endmodule
